// File: design/rmq_pkg.sv
`timescale 1ns / 1ps
package rmq_pkg;

   localparam int IN_W = 18;
   localparam int OUT_W = 18;
   // off-diagonal sums and differences
   localparam int P_W = 19;
   // quotient bits, |quotient| <= 2^17
   localparam int QB = 18;
   localparam int LANES = 3;
   localparam int FRAC_BITS_DEF = 16;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

   typedef enum logic [1:0] {
      COMP_W = 2'd0,
      COMP_X = 2'd1,
      COMP_Y = 2'd2,
      COMP_Z = 2'd3
   } comp_type;

   function automatic int v_width(input int frac);
      return ((frac > 19) ? frac : 19) + 1;
   endfunction

   function automatic int root_width(input int frac);
      return (v_width(frac) + frac + 1) / 2;
   endfunction

   function automatic int latency(input int frac);
      return root_width(frac) + QB + 2;
   endfunction

   function automatic logic [OUT_W-1:0] sat19(input logic signed [P_W:0] v);
      logic [OUT_W-1:0] r;
      if (v > (P_W+1)'(OUT_MAX)) begin
         r = OUT_MAX;
      end else if (v < (P_W+1)'(OUT_MIN)) begin
         r = OUT_MIN;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: design/rmq_select.sv
`timescale 1ns / 1ps
module rmq_select #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
   parameter int VW = rmq_pkg::v_width(FRAC_BITS)
) (
   input  logic clock,
   input  logic reset,
   input  logic valid_in,
   input  logic signed [rmq_pkg::IN_W-1:0] m00,
   input  logic signed [rmq_pkg::IN_W-1:0] m01,
   input  logic signed [rmq_pkg::IN_W-1:0] m02,
   input  logic signed [rmq_pkg::IN_W-1:0] m10,
   input  logic signed [rmq_pkg::IN_W-1:0] m11,
   input  logic signed [rmq_pkg::IN_W-1:0] m12,
   input  logic signed [rmq_pkg::IN_W-1:0] m20,
   input  logic signed [rmq_pkg::IN_W-1:0] m21,
   input  logic signed [rmq_pkg::IN_W-1:0] m22,
   output logic valid_out,
   output logic [VW-1:0] v_out,
   output logic [rmq_pkg::LANES*rmq_pkg::P_W-1:0] p_out,
   output rmq_pkg::comp_type sel_out
);
   localparam int TW = 20;
   localparam int PW = rmq_pkg::P_W;

   logic signed [TW-1:0] tw, tx, ty, tz, best;
   logic signed [PW-1:0] s01, s02, s12, d12, d20, d01;
   rmq_pkg::comp_type sel_in;
   logic [rmq_pkg::LANES*PW-1:0] p_in;
   logic [VW-1:0] v_in;
   logic valid_ff;
   logic [VW-1:0] v_ff;
   logic [rmq_pkg::LANES*PW-1:0] p_ff;
   rmq_pkg::comp_type sel_ff;

   always_comb begin
      tw = TW'(m00) + TW'(m11) + TW'(m22);
      tx = TW'(m00) - TW'(m11) - TW'(m22);
      ty = TW'(m11) - TW'(m00) - TW'(m22);
      tz = TW'(m22) - TW'(m00) - TW'(m11);
      best = tw;
      sel_in = rmq_pkg::COMP_W;
      if (tx > best) begin
         best = tx;
         sel_in = rmq_pkg::COMP_X;
      end
      if (ty > best) begin
         best = ty;
         sel_in = rmq_pkg::COMP_Y;
      end
      if (tz > best) begin
         best = tz;
         sel_in = rmq_pkg::COMP_Z;
      end
      // traces sum to zero, so the winner is never negative
      v_in = VW'(best[TW-2:0]) + (VW'(1) << FRAC_BITS);
      s01 = PW'(m01) + PW'(m10);
      s02 = PW'(m20) + PW'(m02);
      s12 = PW'(m12) + PW'(m21);
      d12 = PW'(m12) - PW'(m21);
      d20 = PW'(m20) - PW'(m02);
      d01 = PW'(m01) - PW'(m10);
      // lanes hold the three remaining components in x, y, z, w order
      case (sel_in)
         rmq_pkg::COMP_W: p_in = {d01, d20, d12};
         rmq_pkg::COMP_X: p_in = {d12, s02, s01};
         rmq_pkg::COMP_Y: p_in = {d20, s12, s01};
         rmq_pkg::COMP_Z: p_in = {d01, s12, s02};
         default:         p_in = {d01, d20, d12};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      v_ff <= v_in;
      p_ff <= p_in;
      sel_ff <= sel_in;
   end

   assign valid_out = valid_ff;
   assign v_out = v_ff;
   assign p_out = p_ff;
   assign sel_out = sel_ff;
endmodule

// File: design/rmq_sqrt_cell.sv
`timescale 1ns / 1ps
module rmq_sqrt_cell #(
   parameter int SW = 16,
   parameter int IDX = 0,
   parameter int PW = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic valid_in,
   input  logic [2*SW-1:0] x_in,
   input  logic [SW+1:0] rem_in,
   input  logic [SW-1:0] root_in,
   input  logic [PW-1:0] pass_in,
   output logic valid_out,
   output logic [2*SW-1:0] x_out,
   output logic [SW+1:0] rem_out,
   output logic [SW-1:0] root_out,
   output logic [PW-1:0] pass_out
);
   logic [SW+1:0] rem_sh, trial, rem_nx;
   logic ge;
   logic valid_ff;
   logic [2*SW-1:0] x_ff;
   logic [SW+1:0] rem_ff;
   logic [SW-1:0] root_ff;
   logic [PW-1:0] pass_ff;

   always_comb begin
      rem_sh = {rem_in[SW-1:0], x_in[2*IDX+1 -: 2]};
      trial = {root_in, 2'b01};
      ge = rem_sh >= trial;
      rem_nx = ge ? rem_sh - trial : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff <= x_in;
      rem_ff <= rem_nx;
      root_ff <= {root_in[SW-2:0], ge};
      pass_ff <= pass_in;
   end

   assign valid_out = valid_ff;
   assign x_out = x_ff;
   assign rem_out = rem_ff;
   assign root_out = root_ff;
   assign pass_out = pass_ff;
endmodule

// File: design/rmq_div_cell.sv
`timescale 1ns / 1ps
module rmq_div_cell #(
   parameter int NW = 35,
   parameter int DW = 20,
   parameter int IDX = 0,
   parameter int PW = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic valid_in,
   input  logic [DW-1:0] d_in,
   input  logic [rmq_pkg::LANES*NW-1:0] rem_in,
   input  logic [rmq_pkg::LANES*rmq_pkg::QB-1:0] q_in,
   input  logic [rmq_pkg::LANES-1:0] neg_in,
   input  logic [PW-1:0] pass_in,
   output logic valid_out,
   output logic [DW-1:0] d_out,
   output logic [rmq_pkg::LANES*NW-1:0] rem_out,
   output logic [rmq_pkg::LANES*rmq_pkg::QB-1:0] q_out,
   output logic [rmq_pkg::LANES-1:0] neg_out,
   output logic [PW-1:0] pass_out
);
   localparam int QB = rmq_pkg::QB;
   localparam int LN = rmq_pkg::LANES;
   localparam int CW = ((DW + QB > NW) ? DW + QB : NW) + 1;

   logic [CW-1:0] dsh;
   logic [LN*NW-1:0] rem_nx;
   logic [LN*QB-1:0] q_nx;
   logic valid_ff;
   logic [DW-1:0] d_ff;
   logic [LN*NW-1:0] rem_ff;
   logic [LN*QB-1:0] q_ff;
   logic [LN-1:0] neg_ff;
   logic [PW-1:0] pass_ff;

   always_comb begin
      dsh = CW'(d_in) << IDX;
      rem_nx = rem_in;
      q_nx = q_in;
      for (int l = 0; l < LN; l++) begin
         if (dsh <= CW'(rem_in[l*NW +: NW])) begin
            rem_nx[l*NW +: NW] = rem_in[l*NW +: NW] - NW'(dsh);
            q_nx[l*QB + IDX] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      d_ff <= d_in;
      rem_ff <= rem_nx;
      q_ff <= q_nx;
      neg_ff <= neg_in;
      pass_ff <= pass_in;
   end

   assign valid_out = valid_ff;
   assign d_out = d_ff;
   assign rem_out = rem_ff;
   assign q_out = q_ff;
   assign neg_out = neg_ff;
   assign pass_out = pass_ff;
endmodule

// File: design/rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 1ps
// channel   ports                                    direction  handshake
// request   req_m00 .. req_m22                       in         start high, busy low
// response  rsp_quat_x/y/z/w, rsp_largest_component  out        rsp_valid, one cycle
//
// one matrix a cycle while busy is low; each beat passes through, in order:
// 1 select stage, one cell per square-root bit, 18 divider cells, 1 output stage
// synchronous reset clears the valid bits of every cell; busy is reset registered,
// so it follows reset in the next cycle. the receiver cannot stall, so nothing ever holds.
module rotation_matrix_to_quaternion_unit #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [rmq_pkg::IN_W-1:0] req_m00,
   input  logic signed [rmq_pkg::IN_W-1:0] req_m01,
   input  logic signed [rmq_pkg::IN_W-1:0] req_m02,
   input  logic signed [rmq_pkg::IN_W-1:0] req_m10,
   input  logic signed [rmq_pkg::IN_W-1:0] req_m11,
   input  logic signed [rmq_pkg::IN_W-1:0] req_m12,
   input  logic signed [rmq_pkg::IN_W-1:0] req_m20,
   input  logic signed [rmq_pkg::IN_W-1:0] req_m21,
   input  logic signed [rmq_pkg::IN_W-1:0] req_m22,
   output logic rsp_valid,
   output logic signed [rmq_pkg::OUT_W-1:0] rsp_quat_x,
   output logic signed [rmq_pkg::OUT_W-1:0] rsp_quat_y,
   output logic signed [rmq_pkg::OUT_W-1:0] rsp_quat_z,
   output logic signed [rmq_pkg::OUT_W-1:0] rsp_quat_w,
   output logic [1:0] rsp_largest_component
);
   localparam int LN = rmq_pkg::LANES;
   localparam int PW = rmq_pkg::P_W;
   localparam int QB = rmq_pkg::QB;
   localparam int VW = rmq_pkg::v_width(FRAC_BITS);
   localparam int SW = rmq_pkg::root_width(FRAC_BITS);
   localparam int BW = SW - 1;
   localparam int DW = BW + 2;
   localparam int NW = PW + FRAC_BITS;
   localparam int SPW = LN * PW + 2;
   localparam int DPW = BW + 2;

   logic busy_ff;
   logic f_valid;
   logic [VW-1:0] f_v;
   logic [LN*PW-1:0] f_p;
   rmq_pkg::comp_type f_sel;

   logic s_valid [0:SW];
   logic [2*SW-1:0] s_x [0:SW];
   logic [SW+1:0] s_rem [0:SW];
   logic [SW-1:0] s_root [0:SW];
   logic [SPW-1:0] s_pass [0:SW];

   logic d_valid [0:QB];
   logic [DW-1:0] d_d [0:QB];
   logic [LN*NW-1:0] d_rem [0:QB];
   logic [LN*QB-1:0] d_q [0:QB];
   logic [LN-1:0] d_neg [0:QB];
   logic [DPW-1:0] d_pass [0:QB];

   logic [BW-1:0] big;
   logic signed [PW-1:0] p_lane;
   logic [LN*NW-1:0] n_init;
   logic [LN-1:0] neg_init;

   logic [BW-1:0] o_big;
   rmq_pkg::comp_type o_sel;
   logic [rmq_pkg::OUT_W-1:0] big_sat;
   logic [rmq_pkg::OUT_W-1:0] lane_sat [0:LN-1];
   logic signed [PW:0] q_signed;
   logic [rmq_pkg::OUT_W-1:0] x_in, y_in, z_in, w_in;

   logic valid_ff;
   logic [rmq_pkg::OUT_W-1:0] x_ff, y_ff, z_ff, w_ff;
   rmq_pkg::comp_type sel_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff;

   rmq_select #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_select (
      .clock(clock), .reset(reset), .valid_in(start && !busy_ff),
      .m00(req_m00), .m01(req_m01), .m02(req_m02),
      .m10(req_m10), .m11(req_m11), .m12(req_m12),
      .m20(req_m20), .m21(req_m21), .m22(req_m22),
      .valid_out(f_valid), .v_out(f_v), .p_out(f_p), .sel_out(f_sel)
   );

   // square root of v << FRAC_BITS, one result bit per cell
   assign s_valid[0] = f_valid;
   assign s_x[0] = (2*SW)'({f_v, {FRAC_BITS{1'b0}}});
   assign s_rem[0] = '0;
   assign s_root[0] = '0;
   assign s_pass[0] = {f_p, f_sel};

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      rmq_sqrt_cell #(.SW(SW), .IDX(SW - 1 - i), .PW(SPW)) u_cell (
         .clock(clock), .reset(reset),
         .valid_in(s_valid[i]), .x_in(s_x[i]), .rem_in(s_rem[i]),
         .root_in(s_root[i]), .pass_in(s_pass[i]),
         .valid_out(s_valid[i+1]), .x_out(s_x[i+1]), .rem_out(s_rem[i+1]),
         .root_out(s_root[i+1]), .pass_out(s_pass[i+1])
      );
   end

   always_comb begin
      big = s_root[SW][SW-1:1];
      for (int l = 0; l < LN; l++) begin
         p_lane = s_pass[SW][2 + l*PW +: PW];
         neg_init[l] = p_lane[PW-1];
         n_init[l*NW +: NW] = NW'(p_lane[PW-1] ? -p_lane : p_lane) << FRAC_BITS;
      end
   end

   // restoring divide of |p| << FRAC_BITS by 4 * big, one quotient bit per cell
   assign d_valid[0] = s_valid[SW];
   assign d_d[0] = {big, 2'b00};
   assign d_rem[0] = n_init;
   assign d_q[0] = '0;
   assign d_neg[0] = neg_init;
   assign d_pass[0] = {big, s_pass[SW][1:0]};

   for (genvar k = 0; k < QB; k++) begin : g_div
      rmq_div_cell #(.NW(NW), .DW(DW), .IDX(QB - 1 - k), .PW(DPW)) u_cell (
         .clock(clock), .reset(reset),
         .valid_in(d_valid[k]), .d_in(d_d[k]), .rem_in(d_rem[k]),
         .q_in(d_q[k]), .neg_in(d_neg[k]), .pass_in(d_pass[k]),
         .valid_out(d_valid[k+1]), .d_out(d_d[k+1]), .rem_out(d_rem[k+1]),
         .q_out(d_q[k+1]), .neg_out(d_neg[k+1]), .pass_out(d_pass[k+1])
      );
   end

   always_comb begin
      o_big = d_pass[QB][DPW-1:2];
      o_sel = rmq_pkg::comp_type'(d_pass[QB][1:0]);
      big_sat = (64'(o_big) > 64'(rmq_pkg::OUT_MAX)) ? rmq_pkg::OUT_MAX
                                                      : rmq_pkg::OUT_W'(o_big);
      for (int l = 0; l < LN; l++) begin
         q_signed = {2'b00, d_q[QB][l*QB +: QB]};
         if (d_neg[QB][l]) begin
            q_signed = -q_signed;
         end
         lane_sat[l] = rmq_pkg::sat19(q_signed);
      end
      case (o_sel)
         rmq_pkg::COMP_W: begin
            x_in = lane_sat[0]; y_in = lane_sat[1]; z_in = lane_sat[2]; w_in = big_sat;
         end
         rmq_pkg::COMP_X: begin
            x_in = big_sat; y_in = lane_sat[0]; z_in = lane_sat[1]; w_in = lane_sat[2];
         end
         rmq_pkg::COMP_Y: begin
            x_in = lane_sat[0]; y_in = big_sat; z_in = lane_sat[1]; w_in = lane_sat[2];
         end
         rmq_pkg::COMP_Z: begin
            x_in = lane_sat[0]; y_in = lane_sat[1]; z_in = big_sat; w_in = lane_sat[2];
         end
         default: begin
            x_in = lane_sat[0]; y_in = lane_sat[1]; z_in = lane_sat[2]; w_in = big_sat;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= d_valid[QB];
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      w_ff <= w_in;
      sel_ff <= o_sel;
   end

   assign rsp_valid = valid_ff;
   assign rsp_quat_x = x_ff;
   assign rsp_quat_y = y_ff;
   assign rsp_quat_z = z_ff;
   assign rsp_quat_w = w_ff;
   assign rsp_largest_component = sel_ff;
endmodule

// File: design/rmq_checker.sv
`timescale 1ns / 1ps
module rmq_checker #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic signed [rmq_pkg::OUT_W-1:0] rsp_quat_x,
   input logic signed [rmq_pkg::OUT_W-1:0] rsp_quat_w,
   input logic [1:0] rsp_largest_component
);
   localparam int LAT = rmq_pkg::latency(FRAC_BITS);

   // every response beat traces back to a request beat a fixed latency earlier
   a_resp_has_req: assert property (@(posedge clock)
      disable iff (reset) rsp_valid |-> $past(start && !busy, LAT))
      else $error("response beat without a matching request beat");

   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid && busy)
      else $error("pipeline not flushed by reset");

   a_busy_drop: assert property (@(posedge clock) !reset |=> !busy)
      else $error("busy held outside reset");

   a_w_nonneg: assert property (@(posedge clock)
      rsp_valid && rsp_largest_component == rmq_pkg::COMP_W |-> !rsp_quat_w[17])
      else $error("square-root component w negative");

   a_x_nonneg: assert property (@(posedge clock)
      rsp_valid && rsp_largest_component == rmq_pkg::COMP_X |-> !rsp_quat_x[17])
      else $error("square-root component x negative");
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_quat_x(rsp_quat_x), .rsp_quat_w(rsp_quat_w),
   .rsp_largest_component(rsp_largest_component)
);
